/* src/rssp_pkg.sv */
// ----------------------------------------------------------------------------
// rssp_pkg: shared definitions for the ramp-and-soak setpoint profile
// Payload types, field widths, register indexes, action and segment codes.
// ----------------------------------------------------------------------------
package rssp_pkg;

    localparam int DURATION_BITS_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;
    localparam int TEMP_BITS_DEF     = 10;

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;

    localparam int ACTION_W    = 2;
    localparam int SYS_TIME_W  = 32;
    localparam int SETPOINT_W  = 10;
    localparam int SEGMENT_W   = 3;
    localparam int ELAPSED_W   = 32;
    localparam int REMAIN_W    = 19;
    localparam int PEAK_W      = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TEMP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_TEMP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_TEMP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HOLD     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HOLD    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_HOLD     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_DURATIONS = 3'd6;

    localparam logic [ACTION_W-1:0] ACT_TIME  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    localparam logic [SEGMENT_W-1:0] SEG_HOLD1 = 3'd0;
    localparam logic [SEGMENT_W-1:0] SEG_RAMP1 = 3'd1;
    localparam logic [SEGMENT_W-1:0] SEG_HOLD2 = 3'd2;
    localparam logic [SEGMENT_W-1:0] SEG_RAMP2 = 3'd3;
    localparam logic [SEGMENT_W-1:0] SEG_HOLD3 = 3'd4;
    localparam logic [SEGMENT_W-1:0] SEG_RAMP3 = 3'd5;
    localparam logic [SEGMENT_W-1:0] SEG_DONE  = 3'd6;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [SYS_TIME_W-1:0] system_time;
    } in_item_t;

    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint;
        logic [SEGMENT_W-1:0]  segment;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [REMAIN_W-1:0]   remaining;
        logic                  running;
        logic [PEAK_W-1:0]     peak_temp;
    } out_item_t;

endpackage

/* src/ramp_soak_setpoint_profile.sv */
// ----------------------------------------------------------------------------
// ramp_soak_setpoint_profile: three-step ramp-and-soak setpoint generator
// Tracks time, start stamp and run flag; reports setpoint, segment, elapsed,
// remaining time and peak temperature for every input transfer.
// ----------------------------------------------------------------------------
// A transfer passes through load, a search of the six segments and setup;
// a running ramp segment then adds the bit-serial multiplier and restoring
// divider. The result is registered in the final state, which waits out an
// output stall; no new transfer is taken until the result is registered.
// Reset clears the run flag, both time stamps and all configuration registers.
module ramp_soak_setpoint_profile #(
    parameter int DURATION_BITS = rssp_pkg::DURATION_BITS_DEF,
    parameter int TIME_BITS     = rssp_pkg::TIME_BITS_DEF,
    parameter int TEMP_BITS     = rssp_pkg::TEMP_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rssp_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rssp_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [rssp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rssp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TB    = TEMP_BITS;
    localparam int DB    = DURATION_BITS;
    localparam int TW    = TIME_BITS;
    localparam int AW    = DB + 3;
    localparam int CW    = (TW > AW) ? TW : AW;
    localparam int PW    = TB + DB;
    localparam int RW    = 3 * DB;
    localparam int MAXC  = (DB > TB) ? DB : TB;
    localparam int CNT_W = $clog2(MAXC + 1);

    localparam int SP_FW  = rssp_pkg::SETPOINT_W;
    localparam int EL_FW  = rssp_pkg::ELAPSED_W;
    localparam int REM_FW = rssp_pkg::REMAIN_W;
    localparam int PK_FW  = rssp_pkg::PEAK_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SETUP  = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic [2:0] LAST_IDX = 3'd5;

    logic [TB-1:0] first_temp_reg;
    logic [TB-1:0] second_temp_reg;
    logic [TB-1:0] third_temp_reg;
    logic [DB-1:0] first_hold_reg;
    logic [DB-1:0] second_hold_reg;
    logic [DB-1:0] third_hold_reg;
    logic [RW-1:0] ramp_dur_reg;

    logic          is_running_reg;
    logic [TW-1:0] start_stamp_reg;
    logic [TW-1:0] now_stamp_reg;

    logic [2:0]                 state_reg;
    logic [TW-1:0]              t_reg;
    logic [AW-1:0]              acc_reg;
    logic [2:0]                 idx_reg;
    logic                       found_reg;
    logic [rssp_pkg::SEGMENT_W-1:0] seg_reg;
    logic [DB-1:0]              pos_reg;
    logic [TB-1:0]              a_reg;
    logic [TB-1:0]              mag_reg;
    logic                       neg_reg;
    logic                       ramp_reg;
    logic [DB-1:0]              len_reg;
    logic [PW-1:0]              prod_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic                       out_valid_reg;
    rssp_pkg::out_item_t        out_data_reg;

    logic [DB-1:0] r1, r2, r3;
    logic [DB-1:0] len_sel;
    logic [AW-1:0] acc_next;
    logic [CW-1:0] t_ext;
    logic [CW-1:0] t_minus_acc;
    logic          hit;

    logic [TB-1:0] base_sel;
    logic [TB-1:0] target_sel;
    logic [DB-1:0] ramp_len_sel;
    logic          is_ramp_seg;

    logic [TB:0]   mul_sum;
    logic [PW-1:0] mul_next;
    logic [DB:0]   div_trial;
    logic [DB:0]   div_diff;
    logic          div_ge;
    logic [DB-1:0] div_rem;
    logic [PW-1:0] div_next;

    logic [TB-1:0] quot;
    logic [TB-1:0] sp_fin;
    logic [CW-1:0] total_ext;
    logic [CW-1:0] remain_full;
    logic [TB-1:0] peak;

    assign r1 = ramp_dur_reg[DB-1:0];
    assign r2 = ramp_dur_reg[2*DB-1:DB];
    assign r3 = ramp_dur_reg[3*DB-1:2*DB];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (idx_reg)
            rssp_pkg::SEG_HOLD1: len_sel = first_hold_reg;
            rssp_pkg::SEG_RAMP1: len_sel = r1;
            rssp_pkg::SEG_HOLD2: len_sel = second_hold_reg;
            rssp_pkg::SEG_RAMP2: len_sel = r2;
            rssp_pkg::SEG_HOLD3: len_sel = third_hold_reg;
            rssp_pkg::SEG_RAMP3: len_sel = r3;
            default:             len_sel = '0;
        endcase
    end

    assign acc_next    = acc_reg + AW'(len_sel);
    assign t_ext       = CW'(t_reg);
    assign t_minus_acc = t_ext - CW'(acc_reg);
    assign hit         = !found_reg && (t_ext < CW'(acc_next));

    always_comb
    begin
        base_sel     = '0;
        target_sel   = '0;
        ramp_len_sel = '0;
        is_ramp_seg  = 1'b0;
        case (seg_reg)
            rssp_pkg::SEG_HOLD1: base_sel = first_temp_reg;
            rssp_pkg::SEG_RAMP1:
            begin
                base_sel     = first_temp_reg;
                target_sel   = second_temp_reg;
                ramp_len_sel = r1;
                is_ramp_seg  = 1'b1;
            end
            rssp_pkg::SEG_HOLD2: base_sel = second_temp_reg;
            rssp_pkg::SEG_RAMP2:
            begin
                base_sel     = second_temp_reg;
                target_sel   = third_temp_reg;
                ramp_len_sel = r2;
                is_ramp_seg  = 1'b1;
            end
            rssp_pkg::SEG_HOLD3: base_sel = third_temp_reg;
            rssp_pkg::SEG_RAMP3:
            begin
                base_sel     = third_temp_reg;
                ramp_len_sel = r3;
                is_ramp_seg  = 1'b1;
            end
            default: base_sel = '0;
        endcase
    end

    // The product builds LSB first: one bit of the position per cycle.
    assign mul_sum  = {1'b0, prod_reg[PW-1:DB]} + (pos_reg[0] ? {1'b0, mag_reg} : '0);
    assign mul_next = {mul_sum, prod_reg[DB-1:1]};

    // Restoring division in place: the upper part holds the partial remainder
    // and quotient bits shift into the bottom.
    assign div_trial = {prod_reg[PW-1:TB], prod_reg[TB-1]};
    assign div_diff  = div_trial - {1'b0, len_reg};
    assign div_ge    = (div_trial >= {1'b0, len_reg});
    assign div_rem   = div_ge ? div_diff[DB-1:0] : div_trial[DB-1:0];
    assign div_next  = {div_rem, prod_reg[TB-2:0], div_ge};

    assign quot   = prod_reg[TB-1:0];
    assign sp_fin = ramp_reg ? (neg_reg ? (a_reg - quot) : (a_reg + quot)) : a_reg;

    assign total_ext   = CW'(acc_reg);
    assign remain_full = (total_ext > t_ext) ? (total_ext - t_ext) : '0;

    always_comb
    begin
        peak = first_temp_reg;
        if (second_temp_reg > peak)
        begin
            peak = second_temp_reg;
        end
        if (third_temp_reg > peak)
        begin
            peak = third_temp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_temp_reg  <= '0;
            second_temp_reg <= '0;
            third_temp_reg  <= '0;
            first_hold_reg  <= '0;
            second_hold_reg <= '0;
            third_hold_reg  <= '0;
            ramp_dur_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rssp_pkg::REG_FIRST_TEMP:     first_temp_reg  <= cfg_data[TB-1:0];
                rssp_pkg::REG_SECOND_TEMP:    second_temp_reg <= cfg_data[TB-1:0];
                rssp_pkg::REG_THIRD_TEMP:     third_temp_reg  <= cfg_data[TB-1:0];
                rssp_pkg::REG_FIRST_HOLD:     first_hold_reg  <= cfg_data[DB-1:0];
                rssp_pkg::REG_SECOND_HOLD:    second_hold_reg <= cfg_data[DB-1:0];
                rssp_pkg::REG_THIRD_HOLD:     third_hold_reg  <= cfg_data[DB-1:0];
                rssp_pkg::REG_RAMP_DURATIONS: ramp_dur_reg    <= RW'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            is_running_reg  <= 1'b0;
            start_stamp_reg <= '0;
            now_stamp_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_data.action)
                            rssp_pkg::ACT_TIME:
                                now_stamp_reg <= TW'(in_data.system_time);
                            rssp_pkg::ACT_START:
                            begin
                                if (!is_running_reg)
                                begin
                                    start_stamp_reg <= now_stamp_reg;
                                    is_running_reg  <= 1'b1;
                                end
                            end
                            rssp_pkg::ACT_STOP:
                                is_running_reg <= 1'b0;
                            default: ;
                        endcase
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    t_reg     <= is_running_reg ? (now_stamp_reg - start_stamp_reg) : '0;
                    acc_reg   <= '0;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    seg_reg   <= rssp_pkg::SEG_DONE;
                    pos_reg   <= '0;
                    state_reg <= S_SEARCH;
                end
                S_SEARCH:
                begin
                    acc_reg <= acc_next;
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        seg_reg   <= idx_reg;
                        pos_reg   <= t_minus_acc[DB-1:0];
                    end
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    a_reg    <= is_running_reg ? base_sel : '0;
                    neg_reg  <= (target_sel < base_sel);
                    mag_reg  <= (target_sel < base_sel) ? (base_sel - target_sel)
                                                        : (target_sel - base_sel);
                    len_reg  <= ramp_len_sel;
                    ramp_reg <= is_running_reg && is_ramp_seg;
                    prod_reg <= '0;
                    cnt_reg  <= '0;
                    state_reg <= (is_running_reg && is_ramp_seg) ? S_MUL : S_FIN;
                end
                S_MUL:
                begin
                    prod_reg <= mul_next;
                    pos_reg  <= {1'b0, pos_reg[DB-1:1]};
                    if (cnt_reg == CNT_W'(DB - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DIV:
                begin
                    prod_reg <= div_next;
                    if (cnt_reg == CNT_W'(TB - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.setpoint  <= SP_FW'(sp_fin);
                        out_data_reg.segment   <= seg_reg;
                        out_data_reg.elapsed   <= EL_FW'(t_reg);
                        out_data_reg.remaining <= REM_FW'(remain_full);
                        out_data_reg.running   <= is_running_reg;
                        out_data_reg.peak_temp <= PK_FW'(peak);
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/rssp_checker.sv */
// ----------------------------------------------------------------------------
// rssp_checker: port-level checks for the ramp-and-soak setpoint profile
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rssp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input rssp_pkg::out_item_t              out_data
);

    // One transfer at a time: the block is busy right after taking one.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");

    a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.segment <= rssp_pkg::SEG_DONE))
        else $error("segment code out of range");

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.running) |->
            (out_data.setpoint == '0 && out_data.elapsed == '0))
        else $error("stopped result has nonzero setpoint or elapsed time");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.segment == rssp_pkg::SEG_DONE) |->
            (out_data.setpoint == '0 && out_data.remaining == '0))
        else $error("finished profile reports setpoint or remaining time");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output changed");

endmodule

bind ramp_soak_setpoint_profile rssp_checker u_rssp_checker (.*);

/* test/ramp_soak_setpoint_profile_tb.sv */
// ----------------------------------------------------------------------------
// ramp_soak_setpoint_profile_tb: self-checking bench for the setpoint profile
// A directed run walks every segment, the skipped zero-length second hold, the
// ignored start and stop actions and a wrapped clock. Random profile runs
// follow under several register settings. A tracker class predicts each
// result from the accepted transfers and compares it field by field.
// Both sides idle at random, and the receiver holds off once long enough to
// back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramp_soak_setpoint_profile_tb;

    localparam int TW = rssp_pkg::TEMP_BITS_DEF;
    localparam int DW = rssp_pkg::DURATION_BITS_DEF;
    localparam int SW = rssp_pkg::TIME_BITS_DEF;
    localparam int AW = rssp_pkg::ACTION_W;
    localparam int IW = rssp_pkg::CFG_INDEX_W;
    localparam int CDW = rssp_pkg::CFG_DATA_W;
    localparam logic [AW-1:0] ACT_NOP = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam int QUIET_LIMIT = 3000;

    class setpoint_tracker;
        bit [TW-1:0] temps[3];
        bit [DW-1:0] holds[3];
        bit [3*DW-1:0] ramps;
        bit is_running;
        bit [SW-1:0] start_stamp;
        bit [SW-1:0] now_stamp;
        rssp_pkg::out_item_t pending_results[$];
        int error_count;

        function void write_register(bit [IW-1:0] idx, bit [CDW-1:0] value);
            case (idx)
                rssp_pkg::REG_FIRST_TEMP: temps[0] = value[TW-1:0];
                rssp_pkg::REG_SECOND_TEMP: temps[1] = value[TW-1:0];
                rssp_pkg::REG_THIRD_TEMP: temps[2] = value[TW-1:0];
                rssp_pkg::REG_FIRST_HOLD: holds[0] = value[DW-1:0];
                rssp_pkg::REG_SECOND_HOLD: holds[1] = value[DW-1:0];
                rssp_pkg::REG_THIRD_HOLD: holds[2] = value[DW-1:0];
                rssp_pkg::REG_RAMP_DURATIONS: ramps = value[3*DW-1:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] segment_length(bit [rssp_pkg::SEGMENT_W-1:0] seg);
            case (seg)
                rssp_pkg::SEG_HOLD1: return 64'(holds[0]);
                rssp_pkg::SEG_RAMP1: return 64'(ramps[DW-1:0]);
                rssp_pkg::SEG_HOLD2: return 64'(holds[1]);
                rssp_pkg::SEG_RAMP2: return 64'(ramps[2*DW-1:DW]);
                rssp_pkg::SEG_HOLD3: return 64'(holds[2]);
                rssp_pkg::SEG_RAMP3: return 64'(ramps[3*DW-1:2*DW]);
                default: return '0;
            endcase
        endfunction

        function bit [63:0] segment_end(bit [rssp_pkg::SEGMENT_W-1:0] seg);
            bit [63:0] acc;
            bit [rssp_pkg::SEGMENT_W-1:0] s;
            acc = '0;
            for (s = rssp_pkg::SEG_HOLD1; s <= seg && s < rssp_pkg::SEG_DONE; s++)
            begin
                acc += segment_length(s);
            end
            return acc;
        endfunction

        function longint ramp_point(longint from_level, longint to_level,
                                    bit [rssp_pkg::SEGMENT_W-1:0] seg, bit [63:0] at);
            longint span_len;
            longint pos;
            span_len = longint'(segment_length(seg));
            pos = longint'(at - (segment_end(seg) - segment_length(seg)));
            return from_level + ((to_level - from_level) * pos) / span_len;
        endfunction

        function rssp_pkg::out_item_t profile_outputs();
            bit [SW-1:0] span;
            bit [63:0] t;
            bit [63:0] total;
            bit [63:0] left;
            bit [rssp_pkg::SEGMENT_W-1:0] seg;
            bit [rssp_pkg::SEGMENT_W-1:0] s;
            bit [TW-1:0] peak;
            longint level;
            rssp_pkg::out_item_t o;
            span = now_stamp - start_stamp;
            t = is_running ? 64'(span) : '0;
            total = segment_end(rssp_pkg::SEG_RAMP3);
            seg = rssp_pkg::SEG_DONE;
            for (s = rssp_pkg::SEG_HOLD1; s < rssp_pkg::SEG_DONE; s++)
            begin
                if (seg == rssp_pkg::SEG_DONE && t < segment_end(s))
                begin
                    seg = s;
                end
            end
            case (seg)
                rssp_pkg::SEG_HOLD1: level = longint'(temps[0]);
                rssp_pkg::SEG_RAMP1:
                    level = ramp_point(longint'(temps[0]), longint'(temps[1]), seg, t);
                rssp_pkg::SEG_HOLD2: level = longint'(temps[1]);
                rssp_pkg::SEG_RAMP2:
                    level = ramp_point(longint'(temps[1]), longint'(temps[2]), seg, t);
                rssp_pkg::SEG_HOLD3: level = longint'(temps[2]);
                rssp_pkg::SEG_RAMP3: level = ramp_point(longint'(temps[2]), 0, seg, t);
                default: level = 0;
            endcase
            if (!is_running)
            begin
                level = 0;
            end
            peak = temps[0];
            if (temps[1] > peak)
            begin
                peak = temps[1];
            end
            if (temps[2] > peak)
            begin
                peak = temps[2];
            end
            left = (total > t) ? total - t : '0;
            o.setpoint = level[rssp_pkg::SETPOINT_W-1:0];
            o.segment = seg;
            o.elapsed = is_running ? span : '0;
            o.remaining = left[rssp_pkg::REMAIN_W-1:0];
            o.running = is_running;
            o.peak_temp = peak;
            return o;
        endfunction

        function void note_transfer(rssp_pkg::in_item_t item);
            case (item.action)
                rssp_pkg::ACT_TIME: now_stamp = item.system_time;
                rssp_pkg::ACT_START:
                begin
                    if (!is_running)
                    begin
                        start_stamp = now_stamp;
                        is_running = 1'b1;
                    end
                end
                rssp_pkg::ACT_STOP: is_running = 1'b0;
                default: ;
            endcase
            pending_results.push_back(profile_outputs());
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(rssp_pkg::out_item_t got);
            rssp_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("setpoint", 32'(want.setpoint), 32'(got.setpoint));
            compare_field("segment", 32'(want.segment), 32'(got.segment));
            compare_field("elapsed", want.elapsed, got.elapsed);
            compare_field("remaining", 32'(want.remaining), 32'(got.remaining));
            compare_field("running", 32'(want.running), 32'(got.running));
            compare_field("peak_temp", 32'(want.peak_temp), 32'(got.peak_temp));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    rssp_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rssp_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [CDW-1:0] cfg_data = '0;

    setpoint_tracker tracker = new();
    int send_calm = 0;
    int sink_calm = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;

    ramp_soak_setpoint_profile i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[ramp_soak_setpoint_profile] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(4, 24);
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic bit [DW-1:0] pick_len(int unsigned top);
        if ($urandom_range(0, 3) == 0)
        begin
            return '0;
        end
        return DW'($urandom_range(1, top));
    endfunction

    initial
    begin : result_sink
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                tracker.check_result(out_data);
                gap_left = draw_wait(sink_calm);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [AW-1:0] act,
                             input logic [rssp_pkg::SYS_TIME_W-1:0] stamp);
        rssp_pkg::in_item_t item;
        int gap;
        item.action = act;
        item.system_time = stamp;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        tracker.note_transfer(item);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit [TW-1:0] t0, input bit [TW-1:0] t1,
                             input bit [TW-1:0] t2, input bit [DW-1:0] h0,
                             input bit [DW-1:0] h1, input bit [DW-1:0] h2,
                             input bit [DW-1:0] r0, input bit [DW-1:0] r1,
                             input bit [DW-1:0] r2);
        bit [CDW-1:0] values[7];
        bit [CDW-1:0] junk;
        int i;
        junk = {$urandom, $urandom};
        values[rssp_pkg::REG_FIRST_TEMP] = {junk[CDW-1:TW], t0};
        values[rssp_pkg::REG_SECOND_TEMP] = {junk[CDW-1:TW], t1};
        values[rssp_pkg::REG_THIRD_TEMP] = {junk[CDW-1:TW], t2};
        values[rssp_pkg::REG_FIRST_HOLD] = {junk[CDW-1:DW], h0};
        values[rssp_pkg::REG_SECOND_HOLD] = {junk[CDW-1:DW], h1};
        values[rssp_pkg::REG_THIRD_HOLD] = {junk[CDW-1:DW], h2};
        values[rssp_pkg::REG_RAMP_DURATIONS] = {r2, r1, r0};
        for (i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= IW'(i);
            cfg_data <= values[i];
            @(posedge clk);
            tracker.write_register(IW'(i), values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Most runs are an optional stop, set a start time, start and then march the clock
    // forward through the segments; the rest is arbitrary traffic.
    task automatic run_profiles(input int quota);
        int first;
        int steps;
        int k;
        bit [63:0] total;
        bit [31:0] stride;
        bit [31:0] origin;
        bit [31:0] offset;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                total = tracker.segment_end(rssp_pkg::SEG_RAMP3);
                stride = 32'(total / 6) + 1;
                if ($urandom_range(0, 3) != 0)
                begin
                    send_item(rssp_pkg::ACT_STOP, $urandom);
                end
                origin = $urandom;
                if ($urandom_range(0, 4) == 0)
                begin
                    origin = 32'hFFFF_FFFF - $urandom_range(0, 32'(total));
                end
                send_item(rssp_pkg::ACT_TIME, origin);
                send_item(rssp_pkg::ACT_START, $urandom);
                offset = 0;
                steps = $urandom_range(3, 12);
                for (k = 0; k < steps; k++)
                begin
                    case ($urandom_range(0, 15))
                        0: send_item(rssp_pkg::ACT_START, $urandom);
                        1: send_item(ACT_NOP, $urandom);
                        2: send_item(rssp_pkg::ACT_TIME, origin - $urandom_range(1, 1000));
                        3:
                        begin
                            offset = 32'(tracker.segment_end(3'($urandom_range(0, 5))))
                                     - $urandom_range(0, 1);
                            send_item(rssp_pkg::ACT_TIME, origin + offset);
                        end
                        4:
                        begin
                            offset = 32'(total) + $urandom_range(0, 100);
                            send_item(rssp_pkg::ACT_TIME, origin + offset);
                        end
                        default:
                        begin
                            offset = offset + $urandom_range(0, stride);
                            send_item(rssp_pkg::ACT_TIME, origin + offset);
                        end
                    endcase
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(rssp_pkg::ACT_STOP, $urandom);
                end
            end
            else
            begin
                send_item(AW'($urandom_range(0, 3)), $urandom);
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hold 5, ramp 10, no second hold, ramp 20 downward, hold 7, ramp 8.
        configure(10'd100, 10'd900, 10'd300, 16'd5, 16'd0, 16'd7, 16'd10, 16'd20, 16'd8);
        send_item(rssp_pkg::ACT_TIME, 32'd0);
        send_item(rssp_pkg::ACT_STOP, 32'hFFFF_FFFF);
        send_item(ACT_NOP, 32'hFFFF_FFFF);
        send_item(rssp_pkg::ACT_TIME, 32'hFFFF_FFFF);
        send_item(rssp_pkg::ACT_TIME, 32'd100);
        send_item(rssp_pkg::ACT_START, 32'd0);
        send_item(rssp_pkg::ACT_START, 32'd7);
        send_item(rssp_pkg::ACT_TIME, 32'd104);
        send_item(rssp_pkg::ACT_TIME, 32'd105);
        send_item(rssp_pkg::ACT_TIME, 32'd112);
        send_item(rssp_pkg::ACT_TIME, 32'd115);
        send_item(rssp_pkg::ACT_TIME, 32'd123);
        send_item(rssp_pkg::ACT_TIME, 32'd136);
        send_item(rssp_pkg::ACT_TIME, 32'd143);
        send_item(rssp_pkg::ACT_TIME, 32'd149);
        send_item(rssp_pkg::ACT_TIME, 32'd150);
        send_item(rssp_pkg::ACT_TIME, 32'd99);
        send_item(rssp_pkg::ACT_STOP, 32'd0);
        send_item(rssp_pkg::ACT_TIME, 32'd0);
        send_item(rssp_pkg::ACT_STOP, 32'd0);
        send_item(rssp_pkg::ACT_START, 32'd0);
        send_item(rssp_pkg::ACT_TIME, 32'hFFFF_FFFF);
        send_item(rssp_pkg::ACT_TIME, 32'd3);
        settle();

        configure('0, '0, '0, '0, '0, '0, '0, '0, '0);
        run_profiles(60);
        settle();

        configure('1, '1, '1, '1, '1, '1, '1, '1, '1);
        run_profiles(40);
        hold_request = 1'b1;
        run_profiles(80);
        settle();

        configure('0, '1, '0, pick_len(30), pick_len(30), pick_len(30),
                  pick_len(30), pick_len(30), pick_len(30));
        run_profiles(140);
        settle();

        configure(TW'($urandom), TW'($urandom), TW'($urandom), pick_len(40), pick_len(40),
                  pick_len(40), pick_len(40), pick_len(40), pick_len(40));
        run_profiles(140);
        settle();

        configure(TW'($urandom), TW'($urandom), TW'($urandom), pick_len(3000),
                  pick_len(3000), pick_len(3000), pick_len(3000), pick_len(3000),
                  pick_len(3000));
        run_profiles(140);
        settle();

        if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
        begin
            $display("[ramp_soak_setpoint_profile] OK");
        end
        else
        begin
            $display("[ramp_soak_setpoint_profile] ERROR");
        end
        $finish;
    end

endmodule
